// ===== rtl/pia_pkg.sv =====
// Package for the positional insert/erase array.
// Holds the operation and status codes, the cell command type and the stream field widths.
// No dependencies.
package pia_pkg;

  localparam int unsigned OP_W     = 3;
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned TDATA_W  = 40;

  typedef enum logic [OP_W-1:0] {
    OP_READ   = 3'd0,
    OP_APPEND = 3'd1,
    OP_POP    = 3'd2,
    OP_INSERT = 3'd3,
    OP_ERASE  = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_INDEX = 2'd1,
    ST_UNDER = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_INSERT = 2'd2,
    CMD_ERASE  = 2'd3
  } cmd_t;

endpackage

// ===== rtl/pia_cell.sv =====
// One storage cell of the positional insert/erase array.
// Holds one element and loads, takes its left or right neighbor, or holds, per command.
// Depends on pia_pkg.
module pia_cell
  import pia_pkg::*;
#(
  parameter int unsigned POS   = 0,
  parameter int unsigned CW    = 5,
  parameter int unsigned WIDTH = 32
) (
  input  logic             clk,
  input  cmd_t             cmd,
  input  logic [CW-1:0]    pos,
  input  logic [CW-1:0]    fill,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [WIDTH-1:0] left_data,
  input  logic [WIDTH-1:0] right_data,
  output logic [WIDTH-1:0] data
);

  localparam logic [CW-1:0] MY_POS  = CW'(POS);
  localparam logic [CW:0]   MY_NEXT = (CW+1)'(POS + 1);

  logic [WIDTH-1:0] data_r;
  logic [WIDTH-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    case (cmd)
      CMD_APPEND: begin
        if (fill == MY_POS) begin
          data_nxt = wr_data;
        end
      end
      CMD_INSERT: begin
        if (pos == MY_POS) begin
          data_nxt = wr_data;
        end else if (MY_POS > pos && MY_POS <= fill) begin
          data_nxt = left_data;
        end
      end
      CMD_ERASE: begin
        if (MY_POS >= pos && MY_NEXT < {1'b0, fill}) begin
          data_nxt = right_data;
        end
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

// ===== rtl/positional_insert_erase_array.sv =====
// Top level of the positional insert/erase array: a bounded ordered store of DEPTH elements.
// Decodes each operation, drives a row of pia_cell instances and registers the result.
// Depends on pia_pkg and pia_cell.
//
// Each input item carries an operation on in_tuser and an index and a value on in_tdata.
// The block reads, appends, pops, inserts or erases, shifting the later elements up or
// down in the row of cells in the same cycle, and returns one result item per input item.
// A result holds the element read or popped, a status and the element count after the
// operation. An index at or beyond the count, a pop on an empty store and a growth of a
// full store are refused with a status and leave the store unchanged.
// The result is registered: it is loaded into the output register on the edge that
// accepts the item. Throughput is one item per cycle while results are taken, set by the
// single update of the cell row and the fill count per item.
// When the receiver stalls, the result waits in the output register and in_tready stays
// low until it is taken; an item is accepted in the same cycle as the waiting result.
// Reset clears the fill count and the output valid flag; element storage is not cleared.
module positional_insert_erase_array
  import pia_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [TDATA_W-1:0] in_tdata,   // index[3:0], value[35:4], zero pad
  input  logic [OP_W-1:0]    in_tuser,   // operation[2:0]
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata,  // read_value[31:0], count[36:32], zero pad
  output logic [STATUS_W-1:0] out_tuser  // status[1:0]
);

  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CMPW = (CW > IDX_W) ? CW : IDX_W;
  localparam int unsigned VW   = (WIDTH < VAL_W) ? WIDTH : VAL_W;
  localparam logic [CW-1:0] FULL_C = CW'(DEPTH);

  logic [IDX_W-1:0] in_index;
  logic [VAL_W-1:0] in_value;
  op_t              in_op;
  logic             in_fire;

  logic [CW-1:0]    fill_r;
  logic [CW-1:0]    fill_nxt;
  logic [CW-1:0]    fill_dec;
  logic [CMPW-1:0]  idx_x;
  logic [CMPW-1:0]  fill_x;
  logic             idx_bad;

  cmd_t             cmd;
  logic [AW-1:0]    rd_sel;
  logic             rd_en;
  status_t          status;
  logic [WIDTH-1:0] wr_data;
  logic [WIDTH-1:0] rd_data;
  logic [WIDTH-1:0] cell_data [DEPTH];

  logic                out_valid_r;
  logic [VAL_W-1:0]    out_value_r;
  logic [COUNT_W-1:0]  out_count_r;
  status_t             out_status_r;

  assign in_index = in_tdata[IDX_W-1:0];
  assign in_value = in_tdata[IDX_W+VAL_W-1:IDX_W];
  assign in_op    = op_t'(in_tuser);
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  assign idx_x    = CMPW'(in_index);
  assign fill_x   = CMPW'(fill_r);
  assign idx_bad  = idx_x >= fill_x;
  assign fill_dec = fill_r - CW'(1);
  assign wr_data  = WIDTH'(in_value[VW-1:0]);
  assign rd_sel   = (in_op == OP_POP) ? fill_dec[AW-1:0] : AW'(in_index);
  assign rd_data  = cell_data[rd_sel];

  always_comb begin
    cmd      = CMD_HOLD;
    fill_nxt = fill_r;
    rd_en    = 1'b0;
    status   = ST_OK;
    case (in_op)
      OP_READ: begin
        if (idx_bad) begin
          status = ST_INDEX;
        end else begin
          rd_en = 1'b1;
        end
      end
      OP_APPEND: begin
        if (fill_r == FULL_C) begin
          status = ST_FULL;
        end else begin
          cmd      = CMD_APPEND;
          fill_nxt = fill_r + CW'(1);
        end
      end
      OP_POP: begin
        if (fill_r == '0) begin
          status = ST_UNDER;
        end else begin
          rd_en    = 1'b1;
          fill_nxt = fill_dec;
        end
      end
      OP_INSERT: begin
        if (idx_bad) begin
          status = ST_INDEX;
        end else if (fill_r == FULL_C) begin
          status = ST_FULL;
        end else begin
          cmd      = CMD_INSERT;
          fill_nxt = fill_r + CW'(1);
        end
      end
      OP_ERASE: begin
        if (idx_bad) begin
          status = ST_INDEX;
        end else begin
          cmd      = CMD_ERASE;
          fill_nxt = fill_dec;
        end
      end
      default: begin
        cmd = CMD_HOLD;
      end
    endcase
    if (!in_fire) begin
      cmd      = CMD_HOLD;
      fill_nxt = fill_r;
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [WIDTH-1:0] left_w;
    logic [WIDTH-1:0] right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_left
      assign left_w = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_right
      assign right_w = cell_data[g+1];
    end
    pia_cell #(
      .POS   (g),
      .CW    (CW),
      .WIDTH (WIDTH)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .pos        (CW'(in_index)),
      .fill       (fill_r),
      .wr_data    (wr_data),
      .left_data  (left_w),
      .right_data (right_w),
      .data       (cell_data[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_value_r  <= rd_en ? VAL_W'(rd_data[VW-1:0]) : '0;
      out_count_r  <= COUNT_W'(fill_nxt);
      out_status_r <= status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(TDATA_W - VAL_W - COUNT_W){1'b0}}, out_count_r, out_value_r};
  assign out_tuser  = out_status_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FULL_C)
    else $error("fill count beyond depth");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted item produced no result");

  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_count_r == COUNT_W'(fill_r))
    else $error("reported count differs from fill count");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == ST_FULL |-> fill_r == FULL_C)
    else $error("full status while store not full");

endmodule
